// File: rtl/core/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared constants and decode helpers for the UTF-8 to UTF-32 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned LenWidth  = 3;
  localparam int unsigned MaxRes    = 3;  // results one byte can release
  localparam int unsigned PendDepth = 3;

  localparam logic [CpWidth-1:0]   ReplacementCp = 21'h00FFFD;
  localparam logic [ByteWidth-1:0] AsciiMax      = 8'h7F;
  localparam logic [1:0]           ContTag       = 2'b10;

  localparam logic [LenWidth-1:0] Len1 = 3'd1;
  localparam logic [LenWidth-1:0] Len2 = 3'd2;
  localparam logic [LenWidth-1:0] Len3 = 3'd3;
  localparam logic [LenWidth-1:0] Len4 = 3'd4;

  // Sequence length announced by a lead byte; stray bytes count as one.
  function automatic logic [LenWidth-1:0] lead_len(logic [ByteWidth-1:0] b);
    logic [LenWidth-1:0] len;
    if (b <= AsciiMax) begin
      len = Len1;
    end else if (b[7:5] == 3'b110) begin
      len = Len2;
    end else if (b[7:4] == 4'b1110) begin
      len = Len3;
    end else if (b[7:3] == 5'b11110) begin
      len = Len4;
    end else begin
      len = Len1;
    end
    return len;
  endfunction

  // Value of one complete sequence of len bytes starting at b0.
  function automatic logic [CpWidth-1:0] seq_value(logic [ByteWidth-1:0] b0,
                                                   logic [ByteWidth-1:0] b1,
                                                   logic [ByteWidth-1:0] b2,
                                                   logic [ByteWidth-1:0] b3,
                                                   logic [LenWidth-1:0]  len);
    logic [CpWidth-1:0] v;
    case (len)
      Len1: begin
        v = (b0 <= AsciiMax) ? {13'd0, b0} : ReplacementCp;
      end
      Len2: begin
        v = (b1[7:6] == ContTag) ? {10'd0, b0[4:0], b1[5:0]} : ReplacementCp;
      end
      Len3: begin
        v = ((b1[7:6] == ContTag) && (b2[7:6] == ContTag)) ?
            {5'd0, b0[3:0], b1[5:0], b2[5:0]} : ReplacementCp;
      end
      default: begin
        v = ((b1[7:6] == ContTag) && (b2[7:6] == ContTag) &&
             (b3[7:6] == ContTag)) ?
            {b0[2:0], b1[5:0], b2[5:0], b3[5:0]} : ReplacementCp;
      end
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/utf8_to_utf32_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder
// Streaming UTF-8 to UTF-32 decoder, one byte in per cycle while input is not held off.
// ----------------------------------------------------------------------------
// A byte accepted at one edge shows its results from the next cycle on, one
// result per cycle while the output is ready, from a three-entry output
// register. A new byte is taken every cycle as long as at most one result is
// waiting and is being taken; a final byte that closes a truncated sequence
// can release up to three results, and input then holds off while the output
// register drains. Lead and continuation bytes are held in a small pending
// buffer; the whole decode of a byte is one pass of mask-and-concat logic
// between that buffer and the output register.
module utf8_to_utf32_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [utf8d_pkg::ByteWidth-1:0] data_byte_i,
  input  logic                            final_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [utf8d_pkg::CpWidth-1:0]   code_point_o,
  output logic                            end_of_string_o
);

  // pending sequence
  logic [utf8d_pkg::ByteWidth-1:0] pend_q [utf8d_pkg::PendDepth];
  logic [1:0]                      pend_cnt_q, pend_cnt_d;
  logic [utf8d_pkg::LenWidth-1:0]  exp_len_q, exp_len_d;

  // output register
  logic [utf8d_pkg::CpWidth-1:0] res_cp_q  [utf8d_pkg::MaxRes];
  logic [utf8d_pkg::CpWidth-1:0] res_cp_d  [utf8d_pkg::MaxRes];
  logic                          res_end_q [utf8d_pkg::MaxRes];
  logic                          res_end_d [utf8d_pkg::MaxRes];
  logic [1:0]                    res_cnt_q, res_cnt_d;

  logic [utf8d_pkg::ByteWidth-1:0] seq_b [8];
  logic [utf8d_pkg::LenWidth-1:0]  n_bytes, need, pos, slot_len, rem;
  logic [utf8d_pkg::CpWidth-1:0]   fin_cp  [utf8d_pkg::MaxRes];
  logic                            fin_end [utf8d_pkg::MaxRes];
  logic [1:0]                      fin_cnt, new_cnt;
  logic [utf8d_pkg::CpWidth-1:0]   full_cp;
  logic                            done, in_acc, pop;

  // held bytes followed by the new one, which also fills the unused slots up to 3; slots 4 to 7 read as zero
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      seq_b[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      seq_b[i] = (2'(i) < pend_cnt_q) ? pend_q[i] : data_byte_i;
    end
    seq_b[3] = data_byte_i;
  end

  assign n_bytes = {1'b0, pend_cnt_q} + 3'd1;
  assign need    = (pend_cnt_q == 2'd0) ? utf8d_pkg::lead_len(data_byte_i) : exp_len_q;
  assign done    = (n_bytes >= need);
  assign full_cp = utf8d_pkg::seq_value(seq_b[0], seq_b[1], seq_b[2], seq_b[3], need);

  // end of string: walk the held bytes and the new one as a complete string
  always_comb begin
    pos      = '0;
    fin_cnt  = '0;
    slot_len = '0;
    rem      = '0;
    for (int k = 0; k < 3; k++) begin
      slot_len = utf8d_pkg::lead_len(seq_b[pos]);
      rem      = n_bytes - pos;
      if ((slot_len > utf8d_pkg::Len1) && (rem < slot_len)) begin
        fin_cp[k] = utf8d_pkg::ReplacementCp;
        slot_len  = utf8d_pkg::Len1;
      end else begin
        fin_cp[k] = utf8d_pkg::seq_value(seq_b[pos], seq_b[pos + 3'd1],
                                         seq_b[pos + 3'd2], seq_b[pos + 3'd3],
                                         slot_len);
      end
      fin_end[k] = ((pos + slot_len) >= n_bytes);
      if (pos < n_bytes) begin
        fin_cnt = fin_cnt + 2'd1;
      end
      pos = pos + slot_len;
    end
  end

  assign in_ready_o = (res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign pop        = out_valid_o && out_ready_i;
  assign new_cnt    = final_byte_i ? fin_cnt : (done ? 2'd1 : 2'd0);

  always_comb begin
    res_cnt_d = res_cnt_q;
    for (int k = 0; k < 3; k++) begin
      res_cp_d[k]  = res_cp_q[k];
      res_end_d[k] = res_end_q[k];
    end
    if (pop) begin
      res_cnt_d    = res_cnt_q - 2'd1;
      res_cp_d[0]  = res_cp_q[1];
      res_cp_d[1]  = res_cp_q[2];
      res_end_d[0] = res_end_q[1];
      res_end_d[1] = res_end_q[2];
    end
    // a load only happens when the register is empty after this cycle
    if (in_acc && (new_cnt != 2'd0)) begin
      res_cnt_d = new_cnt;
      if (final_byte_i) begin
        for (int k = 0; k < 3; k++) begin
          res_cp_d[k]  = fin_cp[k];
          res_end_d[k] = fin_end[k];
        end
      end else begin
        res_cp_d[0]  = full_cp;
        res_end_d[0] = 1'b0;
      end
    end
  end

  always_comb begin
    pend_cnt_d = pend_cnt_q;
    exp_len_d  = exp_len_q;
    if (in_acc) begin
      if (final_byte_i || done) begin
        pend_cnt_d = '0;
        exp_len_d  = '0;
      end else begin
        pend_cnt_d = pend_cnt_q + 2'd1;
        exp_len_d  = need;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= '0;
      exp_len_q  <= '0;
      res_cnt_q  <= '0;
    end else begin
      pend_cnt_q <= pend_cnt_d;
      exp_len_q  <= exp_len_d;
      res_cnt_q  <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !final_byte_i && !done) begin
      pend_q[pend_cnt_q] <= data_byte_i;
    end
    for (int k = 0; k < 3; k++) begin
      res_cp_q[k]  <= res_cp_d[k];
      res_end_q[k] <= res_end_d[k];
    end
  end

  assign out_valid_o     = (res_cnt_q != 2'd0);
  assign code_point_o    = res_cp_q[0];
  assign end_of_string_o = res_end_q[0];

endmodule

// File: rtl/core/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks for the UTF-8 to UTF-32 decoder.
// ----------------------------------------------------------------------------
module utf8d_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [utf8d_pkg::ByteWidth-1:0] data_byte_i,
  input logic                            final_byte_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [utf8d_pkg::CpWidth-1:0]   code_point_o,
  input logic                            end_of_string_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o)
                                    && $stable(end_of_string_o))
    else $error("stalled result changed");

  // a final byte always releases at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && final_byte_i |=> out_valid_o)
    else $error("final byte gave no result");

  // input only backs up behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // nothing is shown right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present after reset");

endmodule

bind utf8_to_utf32_decoder utf8d_checker u_utf8d_checker (.*);

// File: tb/utf8_dec_checker.sv
// ----------------------------------------------------------------------------
// utf8_dec_checker
// Watches both channels of the UTF-8 decoder, predicts the code points that
// each accepted byte releases and compares them in order with the results.
// ----------------------------------------------------------------------------
module utf8_dec_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [utf8d_pkg::ByteWidth-1:0] data_byte_i,
  input  logic                            final_byte_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [utf8d_pkg::CpWidth-1:0]   code_point_i,
  input  logic                            end_of_string_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     owed_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [utf8d_pkg::CpWidth-1:0]   cp_t;
  typedef logic [utf8d_pkg::ByteWidth-1:0] byte_t;

  typedef struct packed {
    cp_t  cp;
    logic eos;
  } code_point_t;

  code_point_t owed_q[$];
  code_point_t oldest;
  byte_t       held_bytes [utf8d_pkg::PendDepth];
  logic [1:0]  held_cnt;
  int unsigned fails;

  // Bytes a lead announces; anything that cannot lead counts as one.
  function automatic int unsigned announced_len(byte_t b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 1;
    endcase
  endfunction

  // Code point of the len-byte sequence that starts at win[at].
  function automatic cp_t assemble(logic [3:0][utf8d_pkg::ByteWidth-1:0] win,
                                   int unsigned at, int unsigned len);
    cp_t         acc;
    int unsigned k;
    if (len == 1) begin
      return win[at][7] ? utf8d_pkg::ReplacementCp : cp_t'(win[at]);
    end
    acc = cp_t'(win[at] & (8'hFF >> (len + 1)));
    for (k = 1; k < len; k++) begin
      if (win[at+k][7:6] != utf8d_pkg::ContTag) begin
        return utf8d_pkg::ReplacementCp;
      end
      acc = (acc << 6) | cp_t'(win[at+k][5:0]);
    end
    return acc;
  endfunction

  function automatic void owe(cp_t cp, logic eos);
    code_point_t item;
    item.cp  = cp;
    item.eos = eos;
    owed_q.push_back(item);
  endfunction

  function automatic void clear_held();
    held_cnt = '0;
    for (int i = 0; i < utf8d_pkg::PendDepth; i++) begin
      held_bytes[i] = '0;
    end
  endfunction

  // One accepted request: append the byte to the open sequence and work out
  // what it releases.
  function automatic void take_byte(byte_t din, logic fin);
    logic [3:0][utf8d_pkg::ByteWidth-1:0] win;
    cp_t                                  cp;
    int unsigned                          n;
    int unsigned                          pos;
    int unsigned                          len;
    win = '0;
    n   = held_cnt;
    for (int i = 0; i < utf8d_pkg::PendDepth; i++) begin
      if (i < n) begin
        win[i] = held_bytes[i];
      end
    end
    win[n] = din;
    n++;
    if (fin) begin
      // string closes: a cut-off lead gives FFFD, the rest is rescanned
      pos = 0;
      while (pos < n) begin
        len = announced_len(win[pos]);
        if (len > 1 && n - pos < len) begin
          cp  = utf8d_pkg::ReplacementCp;
          len = 1;
        end else begin
          cp = assemble(win, pos, len);
        end
        pos += len;
        owe(cp, pos >= n);
      end
      clear_held();
    end else if (n >= announced_len(win[0])) begin
      owe(assemble(win, 0, announced_len(win[0])), 1'b0);
      clear_held();
    end else begin
      for (int i = 0; i < utf8d_pkg::PendDepth; i++) begin
        held_bytes[i] = win[i];
      end
      held_cnt = n[1:0];
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q.delete();
      clear_held();
      fails = 0;
    end else begin
      // results of a byte show up no earlier than the cycle after it is taken, so compare
      // before predicting the byte taken at this edge
      if (out_valid_i && out_ready_i) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: code_point %h end_of_string %b",
                 code_point_i, end_of_string_i);
          fails++;
        end else begin
          oldest = owed_q.pop_front();
          if (code_point_i !== oldest.cp) begin
            $error("code_point: expected %h, got %h", oldest.cp, code_point_i);
            fails++;
          end
          if (end_of_string_i !== oldest.eos) begin
            $error("end_of_string: expected %b, got %b", oldest.eos, end_of_string_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        take_byte(data_byte_i, final_byte_i);
      end
    end
    fail_count_o <= fails;
    owed_count_o <= owed_q.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus for the UTF-8 to UTF-32 decoder: hand-picked strings,
// then random strings of mostly well-formed characters, with idle bursts on
// both sides and one long output hold-off. Checking lives in the checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 160;
  localparam int unsigned QuietTail   = 40;
  localparam int unsigned LongHold    = 64;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned StuckLimit  = 2000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [utf8d_pkg::ByteWidth-1:0] data_byte_i;
  logic                            final_byte_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [utf8d_pkg::CpWidth-1:0]   code_point_o;
  logic                            end_of_string_o;

  int unsigned fail_count;
  int unsigned owed_count;
  bit          idle_en;
  bit          hold_req;

  always #2 clk_i = ~clk_i;

  utf8_to_utf32_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_point_o   (code_point_o),
    .end_of_string_o(end_of_string_o)
  );

  utf8_dec_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_point_i   (code_point_o),
    .end_of_string_i(end_of_string_o),
    .fail_count_o   (fail_count),
    .owed_count_o   (owed_count)
  );

  // Offer one byte request and hold it until the decoder takes it.
  task automatic send_byte(input logic [utf8d_pkg::ByteWidth-1:0] b, input logic fin);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [utf8d_pkg::ByteWidth-1:0] cont_byte();
    return {utf8d_pkg::ContTag, 6'($urandom)};
  endfunction

  // Random string: mostly well-formed characters, some noise bytes, some
  // corrupted continuations, now and then cut off inside a sequence.
  task automatic send_random_string(output int unsigned nbytes);
    logic [utf8d_pkg::ByteWidth-1:0] str_q[$];
    int unsigned                     nchars;
    int unsigned                     len;
    int unsigned                     cut;
    nchars = $urandom_range(1, 6);
    for (int c = 0; c < nchars; c++) begin
      if ($urandom_range(0, 9) == 0) begin
        str_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 4);
        case (len)
          1:       str_q.push_back({1'b0, 7'($urandom)});
          2:       str_q.push_back({3'b110, 5'($urandom)});
          3:       str_q.push_back({4'b1110, 4'($urandom)});
          default: str_q.push_back({5'b11110, 3'($urandom)});
        endcase
        for (int k = 1; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            str_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            str_q.push_back(cont_byte());
          end
        end
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, str_q.size());
      while (str_q.size() > cut) begin
        void'(str_q.pop_back());
      end
    end
    nbytes = str_q.size();
    foreach (str_q[i]) begin
      send_byte(str_q[i], i == str_q.size() - 1);
    end
  endtask

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned rand_sent;
    int unsigned nbytes;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    final_byte_i = 1'b0;
    idle_en      = 1'b1;
    hold_req     = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero byte mid-string, ASCII top, stray continuations and bad leads
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    // two, three and four byte forms, the last one at the 21-bit maximum
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // broken continuation still consumes the full length
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h82, 1'b0);
    // string cut inside a four byte sequence: three results at once
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b1);
    // cut sequence whose tail rescans as ASCII, and a lone final lead
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hC0, 1'b1);

    hold_req  = 1'b1;
    rand_sent = 0;
    while (rand_sent < RandomItems) begin
      idle_en = (rand_sent < RandomItems - QuietTail) && ((rand_sent / 30) % 2 == 0);
      send_random_string(nbytes);
      rand_sent += nbytes;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (owed_count == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
